// ===== rtl/dhs_pkg.sv =====
// Package for the disk head scheduler: mode codes, widths and register indexes.
// No dependencies.
package dhs_pkg;
  localparam int MaxRequests = 32;
  localparam int PositionBits = 16;
  localparam int TravelBits = 22;
  localparam logic [TravelBits-1:0] TravelMax = '1;

  typedef enum logic [2:0] {
    MODE_FCFS  = 3'd0,
    MODE_SSTF  = 3'd1,
    MODE_SCAN  = 3'd2,
    MODE_CSCAN = 3'd3,
    MODE_LOOK  = 3'd4,
    MODE_CLOOK = 3'd5
  } mode_t;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_START = 2'd1;
  localparam logic [1:0] REG_CYLS  = 2'd2;
  localparam logic [1:0] REG_UP    = 2'd3;
endpackage

// ===== rtl/dhs_if.sv =====
// Valid/ready channel interfaces for the scheduler's request and position beats.
// Depends on nothing but its parameters.
interface dhs_req_if #(parameter int PW = 16);
  logic          valid;
  logic          ready;
  logic [PW-1:0] request_cylinder;
  logic          last_request;
  modport source(output valid, request_cylinder, last_request, input ready);
  modport sink(input valid, request_cylinder, last_request, output ready);
endinterface

interface dhs_pos_if #(parameter int PW = 16);
  logic          valid;
  logic          ready;
  logic [PW-1:0] head_position;
  logic [21:0]   total_movement;
  logic          last_position;
  logic          overflow;
  modport source(output valid, head_position, total_movement, last_position, overflow,
                 input ready);
  modport sink(input valid, head_position, total_movement, last_position, overflow,
               output ready);
endinterface

// ===== rtl/dhs_regs.sv =====
// APB-style configuration registers of the scheduler.
// Depends on dhs_pkg.
module dhs_regs #(
  parameter int PW = dhs_pkg::PositionBits
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [3:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic [2:0]    mode,
  output logic [PW-1:0] start_pos,
  output logic [PW-1:0] cyl_count,
  output logic          sweep_up
);
  logic [2:0]    mode_r;
  logic [PW-1:0] start_r;
  logic [PW-1:0] cyls_r;
  logic          up_r;
  logic          wr_en;
  logic [1:0]    idx;

  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx   = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= dhs_pkg::MODE_CLOOK;
      start_r <= PW'(15);
      cyls_r  <= PW'(100);
      up_r    <= 1'b1;
    end else if (wr_en) begin
      unique case (idx)
        dhs_pkg::REG_MODE:  mode_r  <= cfg_pwdata[2:0];
        dhs_pkg::REG_START: start_r <= PW'(cfg_pwdata[15:0]);
        dhs_pkg::REG_CYLS:  cyls_r  <= PW'(cfg_pwdata[15:0]);
        dhs_pkg::REG_UP:    up_r    <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dhs_pkg::REG_MODE:  cfg_prdata = 32'(mode_r);
      dhs_pkg::REG_START: cfg_prdata = 32'(start_r);
      dhs_pkg::REG_CYLS:  cfg_prdata = 32'(cyls_r);
      dhs_pkg::REG_UP:    cfg_prdata = 32'(up_r);
      default:            cfg_prdata = '0;
    endcase
  end

  assign mode      = mode_r;
  assign start_pos = start_r;
  assign cyl_count = cyls_r;
  assign sweep_up  = up_r;
endmodule

// ===== rtl/dhs_core.sv =====
// Sequencer of the scheduler: request memory, scan over stored requests with one
// shared compare unit, and the result register. Depends on dhs_pkg and dhs_if.
module dhs_core #(
  parameter int MAXR = dhs_pkg::MaxRequests,
  parameter int PW   = dhs_pkg::PositionBits
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [2:0]    mode,
  input  logic [PW-1:0] start_pos,
  input  logic [PW-1:0] cyl_count,
  input  logic          sweep_up,
  dhs_req_if.sink       req,
  dhs_pos_if.source     pos
);
  localparam int IW = (MAXR > 1) ? $clog2(MAXR) : 1;
  localparam int CW = $clog2(MAXR + 1);
  localparam int TW = dhs_pkg::TravelBits;

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_LAST  = 6'b000100,
    S_PICK  = 6'b001000,
    S_EMIT  = 6'b010000,
    S_CLEAR = 6'b100000
  } state_t;

  state_t          state_r;
  logic [PW-1:0]   mem [MAXR];
  logic [PW-1:0]   rd_r;
  logic [MAXR-1:0] served_r;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   remain_r;
  logic            drop_r;
  logic [IW-1:0]   idx_r;
  logic [IW-1:0]   best_r;
  logic            found_r;
  logic [PW-1:0]   bval_r;
  logic [PW-1:0]   bdist_r;
  logic [PW-1:0]   head_r;
  logic [PW-1:0]   cur_r;
  logic [PW-1:0]   key_r;
  logic            dir_r;
  logic            wrap_r;
  logic [2:0]      mode_r;
  logic [PW-1:0]   cyls_r;
  logic [TW-1:0]   travel_r;
  logic [PW-1:0]   pend_r;      // pending far-edge move of C-SCAN
  logic            pend_v_r;
  logic [7:0]      guard_r;
  logic            ovf_r;
  logic            out_v_r;
  logic [PW-1:0]   out_pos_r;
  logic [TW-1:0]   out_tot_r;
  logic            out_last_r;
  logic            out_ovf_r;

  // Result move: target and whether it closes the batch.
  logic [PW-1:0]   mv_tgt;
  logic            mv_go;
  logic            mv_last;
  logic            mv_serve;

  // Shared compare unit: looks at entry rd_r (read from index cidx_r in the pipe).
  logic [IW-1:0]   cidx_r;
  logic            cval_r;
  logic            cand;
  logic            better;
  logic [PW-1:0]   cdist;
  logic            is_sweep;
  logic            acc;

  function automatic logic [TW-1:0] mv_sum_c(input logic [TW-1:0] tot,
                                             input logic [PW-1:0] a,
                                             input logic [PW-1:0] b);
    logic [PW-1:0] d;
    logic [TW:0]   s;
    d = (a > b) ? a - b : b - a;
    s = {1'b0, tot} + (TW+1)'(d);
    return s[TW] ? dhs_pkg::TravelMax : s[TW-1:0];
  endfunction

  assign is_sweep = (mode_r == dhs_pkg::MODE_SCAN) || (mode_r == dhs_pkg::MODE_CSCAN) ||
                    (mode_r == dhs_pkg::MODE_LOOK) || (mode_r == dhs_pkg::MODE_CLOOK);

  assign cdist = (rd_r > head_r) ? rd_r - head_r : head_r - rd_r;
  always_comb begin
    cand = cval_r && !served_r[cidx_r];
    better = 1'b0;
    if (mode_r == dhs_pkg::MODE_SSTF) begin
      better = !found_r || cdist < bdist_r || (cdist == bdist_r && rd_r < bval_r);
    end else if (is_sweep) begin
      if (dir_r) better = rd_r >= key_r && (!found_r || rd_r < bval_r);
      else       better = rd_r <= key_r && (!found_r || rd_r > bval_r);
    end else begin
      better = !found_r;  // FCFS: first unserved in arrival order
    end
    cand = cand && better;
  end

  assign req.ready = (state_r == S_LOAD) && !out_v_r;
  assign pos.valid = out_v_r;
  assign pos.head_position  = out_pos_r;
  assign pos.total_movement = out_tot_r;
  assign pos.last_position  = out_last_r;
  assign pos.overflow       = out_ovf_r;

  assign acc = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (acc && count_r < CW'(MAXR)) mem[count_r[IW-1:0]] <= req.request_cylinder;
    rd_r <= mem[idx_r];
  end

  // Decision made at end of a scan (S_PICK).
  always_comb begin
    mv_go    = 1'b0;
    mv_tgt   = bval_r;
    mv_serve = 1'b0;
    if (found_r) begin
      mv_go = 1'b1;
      mv_serve = 1'b1;
    end else if (mode_r == dhs_pkg::MODE_SCAN || mode_r == dhs_pkg::MODE_CSCAN) begin
      mv_go  = !wrap_r;
      mv_tgt = dir_r ? cyls_r : '0;
    end
  end
  assign mv_last = mv_serve && remain_r == CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      served_r <= '0;
      count_r  <= '0;
      drop_r   <= 1'b0;
      out_v_r  <= 1'b0;
      head_r   <= '0;
      travel_r <= '0;
      pend_v_r <= 1'b0;
      dir_r    <= 1'b0;
      wrap_r   <= 1'b0;
      found_r  <= 1'b0;
      cval_r   <= 1'b0;
      idx_r    <= '0;
      remain_r <= '0;
      guard_r  <= '0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (acc) begin
            if (count_r < CW'(MAXR)) count_r <= count_r + 1'b1;
            else drop_r <= 1'b1;
            if (req.last_request) begin
              mode_r   <= mode;
              cyls_r   <= cyl_count;
              dir_r    <= sweep_up;
              head_r   <= start_pos;
              cur_r    <= start_pos;
              key_r    <= start_pos;
              travel_r <= '0;
              ovf_r    <= drop_r || count_r >= CW'(MAXR);
              remain_r <= (count_r < CW'(MAXR)) ? count_r + 1'b1 : count_r;
              guard_r  <= '0;
              wrap_r   <= 1'b0;
              out_v_r    <= 1'b1;
              out_pos_r  <= start_pos;
              out_tot_r  <= '0;
              out_ovf_r  <= drop_r || count_r >= CW'(MAXR);
              out_last_r <= 1'b0;
              state_r <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          // Wait for the result register, then send a pending C-SCAN edge move, begin the next scan or finish.
          if (!out_v_r || pos.ready) begin
            if (pend_v_r) begin
              pend_v_r   <= 1'b0;
              head_r     <= pend_r;
              travel_r   <= (mv_sum_c(travel_r, head_r, pend_r));
              out_v_r    <= 1'b1;
              out_pos_r  <= pend_r;
              out_tot_r  <= mv_sum_c(travel_r, head_r, pend_r);
              out_last_r <= 1'b0;
              out_ovf_r  <= ovf_r;
            end else begin
              out_v_r <= 1'b0;
              if (remain_r == '0) begin
                state_r <= S_CLEAR;
              end else begin
                idx_r   <= '0;
                cval_r  <= 1'b0;
                found_r <= 1'b0;
                state_r <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          cval_r <= 1'b1;
          cidx_r <= idx_r;
          if (cand) begin
            found_r <= 1'b1;
            best_r  <= cidx_r;
            bval_r  <= rd_r;
            bdist_r <= cdist;
          end
          if (CW'(idx_r) == count_r - 1'b1) state_r <= S_LAST;
          else idx_r <= idx_r + 1'b1;
        end
        S_LAST: begin
          cval_r <= 1'b0;
          if (cand) begin
            found_r <= 1'b1;
            best_r  <= cidx_r;
            bval_r  <= rd_r;
            bdist_r <= cdist;
          end
          state_r <= S_PICK;
        end
        S_PICK: begin
          guard_r <= guard_r + 1'b1;
          if (mv_serve) begin
            served_r[best_r] <= 1'b1;
            remain_r <= remain_r - 1'b1;
            key_r    <= bval_r;
            cur_r    <= bval_r;
            wrap_r   <= 1'b0;
          end else if (!is_sweep || wrap_r ||
                       guard_r >= 8'(4 * MAXR + 3)) begin
            remain_r <= '0;   // nothing left to find
          end else if (mode_r == dhs_pkg::MODE_SCAN || mode_r == dhs_pkg::MODE_LOOK) begin
            // The search key stays at the last served request after a turn.
            dir_r <= !dir_r;
            key_r <= cur_r;
          end else begin
            // Circular modes rescan from the far end; C-SCAN adds edge moves to both ends.
            wrap_r <= 1'b1;
            key_r  <= dir_r ? '0 : '1;
            if (mode_r == dhs_pkg::MODE_CSCAN) begin
              pend_v_r <= 1'b1;
              pend_r   <= dir_r ? '0 : cyls_r;
            end
          end
          if (mv_go) begin
            head_r     <= mv_tgt;
            travel_r   <= mv_sum_c(travel_r, head_r, mv_tgt);
            out_v_r    <= 1'b1;
            out_pos_r  <= mv_tgt;
            out_tot_r  <= mv_sum_c(travel_r, head_r, mv_tgt);
            out_last_r <= mv_last;
            out_ovf_r  <= ovf_r;
          end
          if (!mv_serve && (!is_sweep || wrap_r || guard_r >= 8'(4 * MAXR + 3)))
            state_r <= S_CLEAR;
          else state_r <= S_EMIT;
        end
        S_CLEAR: begin
          // Batch closes once the final beat has left.
          if (!out_v_r || pos.ready) begin
            out_v_r  <= 1'b0;
            served_r <= '0;
            count_r  <= '0;
            drop_r   <= 1'b0;
            state_r  <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule

// ===== rtl/disk_head_scheduler_core.sv =====
// Top level of the disk head scheduler: configuration registers and the sequencer.
// Depends on dhs_pkg, dhs_if, dhs_regs and dhs_core.
//
//  channel  direction  beat contents
//  in_      sink       request_cylinder, last_request
//  out_     source     head_position, total_movement, last_position, overflow
//  cfg_     APB slave  scheduling_mode, start_position, cylinder_count, sweep_upward
//
// Request beats are accepted while the sequencer loads; the closing beat starts the schedule and the
// start position is offered on the next cycle.
// Each scan passes the N stored requests through the single compare unit. A served
// position takes one scan, or two when a SCAN or LOOK sweep turns or a C-SCAN or
// C-LOOK sweep wraps; the second C-SCAN edge beat is sent from the emit state
// before the next scan begins.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled output holds the sequencer until the beat is taken.
module disk_head_scheduler_core #(
  parameter int MAX_REQUESTS  = dhs_pkg::MaxRequests,
  parameter int POSITION_BITS = dhs_pkg::PositionBits
) (
  input  logic        clk,
  input  logic        rst_n,
  dhs_req_if.sink     in_chan,
  dhs_pos_if.source   out_chan,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [2:0]               mode;
  logic [POSITION_BITS-1:0] start_pos;
  logic [POSITION_BITS-1:0] cyl_count;
  logic                     sweep_up;

  assign cfg_pready = 1'b1;

  dhs_regs #(.PW(POSITION_BITS)) u_regs (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .mode, .start_pos, .cyl_count, .sweep_up
  );

  dhs_core #(.MAXR(MAX_REQUESTS), .PW(POSITION_BITS)) u_core (
    .clk, .rst_n, .mode, .start_pos, .cyl_count, .sweep_up,
    .req(in_chan), .pos(out_chan)
  );
endmodule
